// ===== design/sseg_pkg.sv =====
// ----------------------------------------------------------------------------
// sseg_pkg
// Types, opcodes, segment table and control store for the seven-segment
// scan unit.
// ----------------------------------------------------------------------------
package sseg_pkg;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [27:0] value;
    logic [2:0]         digit_index;
    logic [2:0]         segment_index;
  } sseg_in_t;

  typedef struct packed {
    logic [7:0] segments;
    logic [2:0] digit_select;
  } sseg_out_t;

  localparam logic [1:0] OP_SHOW  = 2'd0;
  localparam logic [1:0] OP_LIGHT = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_SCAN  = 2'd3;

  localparam logic [7:0] MINUS_PATTERN = 8'h02;
  localparam logic [7:0] BLANK_PATTERN = 8'h00;

  // n / 10 == (n * RECIP_TEN) >> RECIP_SHIFT for every n below 2**32
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef logic [3:0] upc_t;

  // control store addresses
  localparam upc_t UPC_IDLE       = 4'd0;
  localparam upc_t UPC_SHOW_LOAD  = 4'd1;
  localparam upc_t UPC_SHOW_MUL   = 4'd2;
  localparam upc_t UPC_SHOW_WR    = 4'd3;
  localparam upc_t UPC_LIGHT_RD   = 4'd4;
  localparam upc_t UPC_LIGHT_WR   = 4'd5;
  localparam upc_t UPC_CLEAR      = 4'd6;
  localparam upc_t UPC_SCAN_RD    = 4'd7;
  localparam upc_t UPC_SCAN_OUT   = 4'd8;

  // sequencing conditions
  localparam logic [1:0] CND_ALWAYS   = 2'd0;  // go to nxt
  localparam logic [1:0] CND_POS_NZ   = 2'd1;  // loop to nxt while position is not 0
  localparam logic [1:0] CND_WAIT_OUT = 2'd2;  // hold until output slot is free
  localparam logic [1:0] CND_DISPATCH = 2'd3;  // wait for a transfer, branch on op

  // datapath actions
  localparam logic [3:0] ACT_NONE      = 4'd0;
  localparam logic [3:0] ACT_SHOW_LOAD = 4'd1;
  localparam logic [3:0] ACT_SHOW_MUL  = 4'd2;
  localparam logic [3:0] ACT_SHOW_WR   = 4'd3;
  localparam logic [3:0] ACT_LIGHT_RD  = 4'd4;
  localparam logic [3:0] ACT_LIGHT_WR  = 4'd5;
  localparam logic [3:0] ACT_CLEAR     = 4'd6;
  localparam logic [3:0] ACT_SCAN_RD   = 4'd7;
  localparam logic [3:0] ACT_SCAN_OUT  = 4'd8;

  typedef struct packed {
    upc_t       nxt;
    logic [1:0] cond;
    logic [3:0] act;
  } uword_t;

  function automatic uword_t urom(upc_t addr);
    uword_t w;
    case (addr)
      UPC_IDLE:      w = '{nxt: UPC_IDLE,     cond: CND_DISPATCH, act: ACT_NONE};
      UPC_SHOW_LOAD: w = '{nxt: UPC_SHOW_MUL, cond: CND_ALWAYS,   act: ACT_SHOW_LOAD};
      UPC_SHOW_MUL:  w = '{nxt: UPC_SHOW_WR,  cond: CND_ALWAYS,   act: ACT_SHOW_MUL};
      UPC_SHOW_WR:   w = '{nxt: UPC_SHOW_MUL, cond: CND_POS_NZ,   act: ACT_SHOW_WR};
      UPC_LIGHT_RD:  w = '{nxt: UPC_LIGHT_WR, cond: CND_ALWAYS,   act: ACT_LIGHT_RD};
      UPC_LIGHT_WR:  w = '{nxt: UPC_IDLE,     cond: CND_ALWAYS,   act: ACT_LIGHT_WR};
      UPC_CLEAR:     w = '{nxt: UPC_IDLE,     cond: CND_ALWAYS,   act: ACT_CLEAR};
      UPC_SCAN_RD:   w = '{nxt: UPC_SCAN_OUT, cond: CND_ALWAYS,   act: ACT_SCAN_RD};
      UPC_SCAN_OUT:  w = '{nxt: UPC_IDLE,     cond: CND_WAIT_OUT, act: ACT_SCAN_OUT};
      default:       w = '{nxt: UPC_IDLE,     cond: CND_ALWAYS,   act: ACT_NONE};
    endcase
    return w;
  endfunction

  function automatic upc_t op_entry(logic [1:0] op);
    upc_t e;
    case (op)
      OP_SHOW:  e = UPC_SHOW_LOAD;
      OP_LIGHT: e = UPC_LIGHT_RD;
      OP_CLEAR: e = UPC_CLEAR;
      OP_SCAN:  e = UPC_SCAN_RD;
      default:  e = UPC_IDLE;
    endcase
    return e;
  endfunction

  function automatic logic [7:0] seg_code(logic [3:0] digit);
    logic [7:0] s;
    case (digit)
      4'd0:    s = 8'hfc;
      4'd1:    s = 8'h60;
      4'd2:    s = 8'hda;
      4'd3:    s = 8'hf2;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'hb6;
      4'd6:    s = 8'hbe;
      4'd7:    s = 8'he0;
      4'd8:    s = 8'hfe;
      4'd9:    s = 8'hf6;
      default: s = BLANK_PATTERN;
    endcase
    return s;
  endfunction

endpackage

// ===== design/signed_int_seven_segment_scan_unit.sv =====
// ----------------------------------------------------------------------------
// signed_int_seven_segment_scan_unit
// Digit store for a multiplexed seven-segment display, run by a small
// microprogram: show a signed integer, light a segment, clear, scan.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command per transfer (op, value, digit_index, segment_index).
//   out_* : one result per scan tick: the segment byte of the scanned digit
//           and its position. Other commands give no result.
//   Steps per command:
//     show integer  one reciprocal multiply per digit, then one store write,
//                   position by position
//     light segment read-modify-write of one store entry
//     clear         clears all store valid bits
//     scan tick     store read, then the output register once it is free
//   The store has one write and one read port, so every command walks the
//   control store one step per cycle, bar the scan tick stall below, and only
//   one command is in flight. Reset clears the store valid bits (all digits
//   blank), the scan position and the output valid bit. A stalled receiver
//   holds the result in the output register; commands keep flowing until the
//   next scan tick, which waits for the register to empty.
// ----------------------------------------------------------------------------
module signed_int_seven_segment_scan_unit
  import sseg_pkg::*;
#(
  parameter int DIGIT_COUNT = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sseg_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output sseg_out_t out_data
);

  localparam int             IW       = (DIGIT_COUNT > 2) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [IW-1:0]  LAST_POS = IW'(DIGIT_COUNT - 1);

  uword_t          uw;
  upc_t            upc_r, upc_nxt;
  logic            in_xfer, out_free, pos_nz;

  sseg_in_t        item_r;
  logic [27:0]     mag_r, quo_r, load_mag, rem_full;
  logic [59:0]     prod;
  logic [3:0]      rem;
  logic            neg_r, minus_r, digit_wr;
  logic [IW-1:0]   pos_r, scan_r, light_addr, rd_addr, wr_addr;
  logic [7:0]      show_byte, rd_byte_r, rd_data, wr_byte, light_mask;
  logic            rd_vld_r, wr_en, light_ok, rd_en;

  logic [7:0]             mem [DIGIT_COUNT];
  logic [DIGIT_COUNT-1:0] vld_r;

  sseg_out_t       out_r;
  logic            out_valid_r;

  // ---------------- sequencer ----------------
  assign uw       = urom(upc_r);
  assign in_ready = (uw.cond == CND_DISPATCH);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign pos_nz   = (pos_r != '0);

  always_comb begin
    case (uw.cond)
      CND_ALWAYS:   upc_nxt = uw.nxt;
      CND_POS_NZ:   upc_nxt = pos_nz ? uw.nxt : UPC_IDLE;
      CND_WAIT_OUT: upc_nxt = out_free ? uw.nxt : upc_r;
      CND_DISPATCH: upc_nxt = in_xfer ? op_entry(in_data.op) : upc_r;
      default:      upc_nxt = UPC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UPC_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // ---------------- decimal conversion datapath ----------------
  assign load_mag = item_r.value[27] ? (~item_r.value + 28'd1) : item_r.value;
  assign prod     = 60'(mag_r) * 60'(RECIP_TEN);
  assign rem_full = mag_r - ((quo_r << 3) + (quo_r << 1));
  assign rem      = rem_full[3:0];

  // digit while magnitude remains (or single zero), keep position 0 for the minus
  assign digit_wr = ((mag_r != '0) || (pos_r == LAST_POS)) && (!neg_r || pos_nz);

  always_comb begin
    if (digit_wr) begin
      show_byte = seg_code(rem);
    end else if (neg_r && !minus_r) begin
      show_byte = MINUS_PATTERN;
    end else begin
      show_byte = BLANK_PATTERN;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= in_data;
    end
    case (uw.act)
      ACT_SHOW_LOAD: begin
        neg_r   <= item_r.value[27];
        mag_r   <= load_mag;
        pos_r   <= LAST_POS;
        minus_r <= 1'b0;
      end
      ACT_SHOW_MUL: begin
        quo_r <= 28'(prod >> RECIP_SHIFT);
      end
      ACT_SHOW_WR: begin
        if (digit_wr) begin
          mag_r <= quo_r;
        end else if (neg_r) begin
          minus_r <= 1'b1;
        end
        if (pos_nz) begin
          pos_r <= pos_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------- digit store ----------------
  assign light_addr = IW'(item_r.digit_index);
  assign light_ok   = (5'(item_r.digit_index) < 5'(DIGIT_COUNT));
  assign light_mask = 8'd1 << (~item_r.segment_index);
  assign rd_en      = (uw.act == ACT_SCAN_RD) || (uw.act == ACT_LIGHT_RD);
  assign rd_addr    = (uw.act == ACT_SCAN_RD) ? scan_r : light_addr;
  assign rd_data    = rd_vld_r ? rd_byte_r : BLANK_PATTERN;

  always_comb begin
    case (uw.act)
      ACT_SHOW_WR: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        wr_byte = show_byte;
      end
      ACT_LIGHT_WR: begin
        wr_en   = light_ok;
        wr_addr = light_addr;
        wr_byte = rd_data | light_mask;
      end
      default: begin
        wr_en   = 1'b0;
        wr_addr = pos_r;
        wr_byte = show_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_byte;
    end
    if (rd_en) begin
      rd_byte_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  // an entry without its valid bit reads as blank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (uw.act == ACT_CLEAR) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // ---------------- scan position and output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else if ((uw.act == ACT_SCAN_OUT) && out_free) begin
      scan_r      <= (scan_r == LAST_POS) ? '0 : scan_r + 1'b1;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((uw.act == ACT_SCAN_OUT) && out_free) begin
      out_r.segments     <= rd_data;
      out_r.digit_select <= 3'(scan_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/sseg_chk.sv =====
// ----------------------------------------------------------------------------
// sseg_chk
// Port-level checks for the seven-segment scan unit, bound to the top level.
// ----------------------------------------------------------------------------
module sseg_chk
  import sseg_pkg::*;
#(
  parameter int DIGIT_COUNT = 8
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input sseg_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input sseg_out_t out_data
);

  localparam int            IW       = (DIGIT_COUNT > 2) ? $clog2(DIGIT_COUNT) : 1;
  localparam logic [IW-1:0] LAST_POS = IW'(DIGIT_COUNT - 1);

  logic          in_xfer, out_xfer, scan_acc;
  logic [IW-1:0] exp_sel_r;
  logic [1:0]    pend_r, pend_nxt;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign scan_acc = in_xfer && (in_data.op == OP_SCAN);

  always_comb begin
    case ({scan_acc, out_xfer})
      2'b10:   pend_nxt = pend_r + 2'd1;
      2'b01:   pend_nxt = pend_r - 2'd1;
      default: pend_nxt = pend_r;
    endcase
  end

  // track scan ticks not yet delivered and the position the next result shows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_sel_r <= '0;
      pend_r    <= '0;
    end else begin
      pend_r <= pend_nxt;
      if (out_xfer) begin
        exp_sel_r <= (exp_sel_r == LAST_POS) ? '0 : exp_sel_r + 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> out_data.digit_select == 3'(exp_sel_r))
    else $error("scanned position out of order");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a pending scan tick");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("command taken while previous one still running");

endmodule

bind signed_int_seven_segment_scan_unit sseg_chk #(.DIGIT_COUNT(DIGIT_COUNT)) u_sseg_chk (.*);

// ===== bench/signed_int_seven_segment_scan_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_seven_segment_scan_unit_tb
// Drives show, light, clear and scan commands into the scan unit, directed
// and then in random bursts, while the result side stalls on its own pattern.
// A scoreboard keeps a shadow digit store and scan position, predicts every
// scan byte and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module signed_int_seven_segment_scan_unit_tb;
  import sseg_pkg::*;

  localparam int DIGITS = 8;

  class scan_scoreboard;
    logic [7:0]  digit_store [DIGITS];
    int unsigned cursor;
    sseg_out_t   scans_due [$];
    int          errors;

    function new();
      foreach (digit_store[i]) digit_store[i] = BLANK_PATTERN;
      cursor = 0;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      errors++;
    endtask

    function logic [7:0] seg_lookup(input int unsigned d);
      logic [7:0] lut [10] = '{8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66,
                               8'hb6, 8'hbe, 8'he0, 8'hfe, 8'hf6};
      return lut[d];
    endfunction

    function void show_number(input logic [27:0] bits);
      logic        negative;
      int unsigned mag;
      int          limit;
      int          pos;
      int          used;
      negative = bits[27];
      mag = negative ? (32'h1000_0000 - {4'b0, bits}) : {4'b0, bits};
      limit = negative ? DIGITS - 1 : DIGITS;
      pos = DIGITS - 1;
      used = 0;
      foreach (digit_store[i]) digit_store[i] = BLANK_PATTERN;
      if (mag == 0) begin
        digit_store[DIGITS - 1] = seg_lookup(0);
        return;
      end
      while (mag != 0 && used < limit) begin
        digit_store[pos] = seg_lookup(mag % 10);
        mag = mag / 10;
        pos--;
        used++;
      end
      if (negative && pos >= 0) digit_store[pos] = MINUS_PATTERN;
    endfunction

    function void note_input(input sseg_in_t cmd);
      sseg_out_t due;
      case (cmd.op)
        OP_SHOW:  show_number(cmd.value);
        OP_LIGHT: begin
          if (cmd.digit_index < DIGITS)
            digit_store[cmd.digit_index] |= 8'h80 >> cmd.segment_index;
        end
        OP_CLEAR: foreach (digit_store[i]) digit_store[i] = BLANK_PATTERN;
        OP_SCAN:  begin
          if (cursor >= DIGITS) cursor = 0;
          due.segments = digit_store[cursor];
          due.digit_select = cursor[2:0];
          scans_due.push_back(due);
          cursor++;
          if (cursor >= DIGITS) cursor = 0;
        end
        default: ;
      endcase
    endfunction

    task check_result(input sseg_out_t got);
      sseg_out_t due;
      if (scans_due.size() == 0) begin
        report($sformatf("unexpected result seg=%02h sel=%0d", got.segments, got.digit_select));
        return;
      end
      due = scans_due.pop_front();
      if (got.segments !== due.segments)
        report($sformatf("segments %02h, want %02h (sel %0d)",
                         got.segments, due.segments, due.digit_select));
      if (got.digit_select !== due.digit_select)
        report($sformatf("digit_select %0d, want %0d", got.digit_select, due.digit_select));
    endtask

    function int pending();
      return scans_due.size();
    endfunction

    task close_out();
      if (scans_due.size() != 0)
        report($sformatf("%0d scan results never arrived", scans_due.size()));
    endtask
  endclass

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  sseg_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  sseg_out_t out_data;

  scan_scoreboard sb = new();

  signed_int_seven_segment_scan_unit #(.DIGIT_COUNT(DIGITS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: check transfers, then pick the next ready level
  int          ready_run = 0;
  logic        ready_level = 1'b1;
  int unsigned ready_mode = 0;
  int unsigned mode_age = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    mode_age++;
    if (mode_age >= 300) begin
      mode_age = 0;
      ready_mode = $urandom_range(0, 2);
    end
    if (ready_run == 0) begin
      case (ready_mode)
        0: begin
          ready_level = 1'b1;
          ready_run = $urandom_range(1, 50);
        end
        1: begin
          ready_level = 1'($urandom_range(0, 1));
          ready_run = $urandom_range(0, 2);
        end
        default: begin
          ready_level = ~ready_level;
          ready_run = ready_level ? $urandom_range(1, 4) : $urandom_range(1, 25);
        end
      endcase
    end else begin
      ready_run--;
    end
    out_ready <= ready_level;
  end

  function automatic sseg_in_t make_cmd(input logic [1:0] op, input int value,
                                        input int digit, input int seg);
    sseg_in_t cmd;
    cmd.op = op;
    cmd.value = value[27:0];
    cmd.digit_index = digit[2:0];
    cmd.segment_index = seg[2:0];
    return cmd;
  endfunction

  function automatic int random_value();
    int          pick;
    int unsigned span;
    int unsigned mag;
    int          extremes [8] = '{99999999, -9999999, 0, 134217727, -134217728, -1,
                                  10000000, -1000000};
    pick = $urandom_range(0, 99);
    if (pick < 10) return $signed({$urandom} << 4) >>> 4;
    if (pick < 25) return $urandom_range(0, 40) - 20;
    if (pick < 32) return extremes[$urandom_range(0, 7)];
    span = 1;
    repeat ($urandom_range(1, 8)) span = span * 10;
    mag = $urandom_range(0, span - 1);
    if ($urandom_range(0, 2) == 0) return -int'(mag % 10000000);
    return int'(mag);
  endfunction

  function automatic sseg_in_t random_cmd();
    sseg_in_t    cmd;
    int unsigned pick;
    cmd = sseg_in_t'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      cmd.op = OP_SHOW;
      cmd.value = 28'(random_value());
    end else if (pick < 40) begin
      cmd.op = OP_LIGHT;
    end else if (pick < 43) begin
      cmd.op = OP_CLEAR;
    end else begin
      cmd.op = OP_SCAN;
    end
    return cmd;
  endfunction

  // valid stays high across back-to-back transfers; only a pause drops it
  task automatic send_cmd(input sseg_in_t cmd);
    in_valid <= 1'b1;
    in_data <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(cmd);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    in_data <= sseg_in_t'({$urandom, $urandom});
    repeat (cycles) @(posedge clk);
  endtask

  int sent;
  int burst;
  int gap;

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a full sweep of a negative value that fills every position
    send_cmd(make_cmd(OP_SHOW, -9999999, 0, 0));
    repeat (8) send_cmd(make_cmd(OP_SCAN, 0, 0, 0));
    // negative with too many digits keeps the minus in the first position
    send_cmd(make_cmd(OP_SHOW, -134217728, 0, 0));
    send_cmd(make_cmd(OP_SCAN, 0, 0, 0));
    // positive with too many digits keeps the lowest eight
    send_cmd(make_cmd(OP_SHOW, 134217727, 0, 0));
    send_cmd(make_cmd(OP_SCAN, 0, 0, 0));
    // inner zeros are shown, not blanked
    send_cmd(make_cmd(OP_SHOW, 10000001, 0, 0));
    send_cmd(make_cmd(OP_SCAN, 0, 0, 0));
    send_cmd(make_cmd(OP_SHOW, 0, 0, 0));
    send_cmd(make_cmd(OP_LIGHT, 0, 5, 0));
    send_cmd(make_cmd(OP_LIGHT, 0, 5, 7));
    send_cmd(make_cmd(OP_SCAN, 0, 0, 0));
    send_cmd(make_cmd(OP_SCAN, 0, 0, 0));
    send_cmd(make_cmd(OP_CLEAR, 0, 0, 0));
    send_cmd(make_cmd(OP_SCAN, 0, 0, 0));
    send_cmd(make_cmd(OP_SHOW, -1, 0, 0));
    send_cmd(make_cmd(OP_SCAN, 0, 0, 0));
    pause_sender(3);

    sent = 0;
    while (sent < 2000) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 10);
      repeat (burst) begin
        send_cmd(random_cmd());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) pause_sender(gap);
    end
    pause_sender(1);

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sseg_pkg.sv
design/signed_int_seven_segment_scan_unit.sv
design/sseg_chk.sv
bench/signed_int_seven_segment_scan_unit_tb.sv
